### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the vector normaliser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge outside reset.
`define NV3_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// An implication checked at every rising edge outside reset.
`define NV3_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/nv3_pkg.sv
// ----------------------------------------------------------------------------
// nv3_pkg
// Widths, the queued item type and the arithmetic steps of the normaliser.
// ----------------------------------------------------------------------------
package nv3_pkg;

	localparam int VecW       = 16;
	localparam int MinW       = 16;
	localparam int UnitW      = 16;
	localparam int SqW        = 31;
	localparam int SumW       = 32;
	localparam int QuoW       = 31;
	localparam int RootW      = 16;
	localparam int RemW       = 17;
	localparam int DivSteps   = QuoW;
	localparam int SqrtSteps  = RootW;
	localparam int QueueDepth = 4;
	localparam logic [UnitW-1:0] UnitOne = 16'd16384;

	typedef struct packed {
		logic                    degen;
		logic [2:0]              neg;
		logic [SumW-1:0]         sum;
		logic [2:0][SqW-1:0]     sq;
	} nv3_item_t;

	typedef struct packed {
		logic            qbit;
		logic [SumW-1:0] rem;
	} nv3_div_t;

	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [RootW-1:0] root;
	} nv3_sqrt_t;

	// One restoring division step.
	function automatic nv3_div_t div_step(logic [SumW-1:0] rem, logic nbit,
			logic [SumW-1:0] den);
		logic [SumW:0] sh;
		nv3_div_t      r;
		sh = {rem, nbit};
		if (sh >= {1'b0, den}) begin
			r.qbit = 1'b1;
			r.rem  = SumW'(sh - {1'b0, den});
		end else begin
			r.qbit = 1'b0;
			r.rem  = sh[SumW-1:0];
		end
		return r;
	endfunction

	// One digit of the binary digit-by-digit square root.
	function automatic nv3_sqrt_t sqrt_step(logic [RemW-1:0] rem, logic [1:0] pair,
			logic [RootW-1:0] root);
		logic [RemW+1:0] sh;
		logic [RemW+1:0] trial;
		nv3_sqrt_t       r;
		sh    = {rem, pair};
		trial = (RemW+2)'({root, 2'b01});
		if (sh >= trial) begin
			r.rem  = RemW'(sh - trial);
			r.root = {root[RootW-2:0], 1'b1};
		end else begin
			r.rem  = sh[RemW-1:0];
			r.root = {root[RootW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

### sv/nv3_front.sv
// ----------------------------------------------------------------------------
// nv3_front
// Accepts vectors, squares the components and flags degenerate ones.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nv3_front import nv3_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [MinW-1:0]        min_length,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [VecW-1:0] vec_x,
	input  logic signed [VecW-1:0] vec_y,
	input  logic signed [VecW-1:0] vec_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output nv3_item_t              out_item
);

	logic                      v_s1;
	logic                      v_s2;
	logic [2:0][SqW-1:0]       sq_s1;
	logic [2:0]                neg_s1;
	nv3_item_t                 item_s2;
	logic [SumW-1:0]           min_sq_q;
	logic signed [2*VecW-1:0]  prod_x;
	logic signed [2*VecW-1:0]  prod_y;
	logic signed [2*VecW-1:0]  prod_z;
	logic [SumW-1:0]           sum;
	logic                      en;

	assign en        = !v_s2 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s2;
	assign out_item  = item_s2;

	assign prod_x = vec_x * vec_x;
	assign prod_y = vec_y * vec_y;
	assign prod_z = vec_z * vec_z;
	assign sum    = SumW'(sq_s1[0]) + SumW'(sq_s1[1]) + SumW'(sq_s1[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		min_sq_q <= SumW'(min_length) * SumW'(min_length);
		if (en) begin
			sq_s1[0]      <= prod_x[SqW-1:0];
			sq_s1[1]      <= prod_y[SqW-1:0];
			sq_s1[2]      <= prod_z[SqW-1:0];
			neg_s1        <= {vec_z[VecW-1], vec_y[VecW-1], vec_x[VecW-1]};
			item_s2.sq    <= sq_s1;
			item_s2.neg   <= neg_s1;
			item_s2.sum   <= sum;
			item_s2.degen <= (sum <= min_sq_q);
		end
	end

	`NV3_IMPLY(a_zero_degen, v_s2 && item_s2.sum == '0, item_s2.degen, "zero vector not degenerate")

endmodule

### sv/nv3_queue.sv
// ----------------------------------------------------------------------------
// nv3_queue
// Short register queue between the front and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nv3_queue import nv3_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  nv3_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output nv3_item_t pop_item
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	nv3_item_t           mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CntW'(push) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`NV3_ASSERT(a_count, 1'b1 |=> count_q == $past(count_q) + CntW'($past(push)) - CntW'($past(pop)), "queue count slipped")

endmodule

### sv/nv3_back.sv
// ----------------------------------------------------------------------------
// nv3_back
// Divides each squared component by the sum of squares, takes the square
// root of the quotient and rounds the result to a signed Q1.14 component.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nv3_back import nv3_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  nv3_item_t               in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [UnitW-1:0] unit_x,
	output logic signed [UnitW-1:0] unit_y,
	output logic signed [UnitW-1:0] unit_z,
	output logic                    degenerate
);

	logic                                    en;
	logic [DivSteps-1:0]                     dv_s;
	logic [DivSteps-1:0][2:0]                dneg_s;
	logic [DivSteps-1:0]                     ddeg_s;
	logic [DivSteps-1:0][SumW-1:0]           dsum_s;
	logic [DivSteps-1:0][2:0][SumW-1:0]      drem_s;
	logic [DivSteps-1:0][2:0][QuoW-1:0]      dquo_s;
	logic [DivSteps-1:0][2:0][SumW-1:0]      drem_d;
	logic [DivSteps-1:0][2:0][QuoW-1:0]      dquo_d;
	logic [SqrtSteps-1:0]                    sv_s;
	logic [SqrtSteps-1:0][2:0]               sneg_s;
	logic [SqrtSteps-1:0]                    sdeg_s;
	logic [SqrtSteps-1:0][2:0][QuoW:0]       sqv_s;
	logic [SqrtSteps-1:0][2:0][RemW-1:0]     srem_s;
	logic [SqrtSteps-1:0][2:0][RootW-1:0]    sroot_s;
	logic [SqrtSteps-1:0][2:0][QuoW:0]       sqv_d;
	logic [SqrtSteps-1:0][2:0][RemW-1:0]     srem_d;
	logic [SqrtSteps-1:0][2:0][RootW-1:0]    sroot_d;
	logic [2:0][UnitW-1:0]                   unit_d;
	logic [2:0][UnitW-1:0]                   unit_q;
	logic                                    out_v_q;
	logic                                    deg_q;

	assign en         = !out_v_q || out_ready;
	assign in_ready   = en;
	assign out_valid  = out_v_q;
	assign unit_x     = unit_q[0];
	assign unit_y     = unit_q[1];
	assign unit_z     = unit_q[2];
	assign degenerate = deg_q;

	always_comb begin
		nv3_div_t r;
		for (int c = 0; c < 3; c++) begin
			r = div_step(SumW'(in_item.sq[c][SqW-1:1]), in_item.sq[c][0], in_item.sum);
			drem_d[0][c] = r.rem;
			dquo_d[0][c] = QuoW'(r.qbit);
			for (int k = 1; k < DivSteps; k++) begin
				r = div_step(drem_s[k-1][c], 1'b0, dsum_s[k-1]);
				drem_d[k][c] = r.rem;
				dquo_d[k][c] = {dquo_s[k-1][c][QuoW-2:0], r.qbit};
			end
		end
	end

	always_comb begin
		nv3_sqrt_t        r;
		logic [QuoW:0]    qv;
		for (int c = 0; c < 3; c++) begin
			qv = {1'b0, dquo_s[DivSteps-1][c]};
			r  = sqrt_step('0, qv[QuoW:QuoW-1], '0);
			sqv_d[0][c]   = {qv[QuoW-2:0], 2'b00};
			srem_d[0][c]  = r.rem;
			sroot_d[0][c] = r.root;
			for (int j = 1; j < SqrtSteps; j++) begin
				qv = sqv_s[j-1][c];
				r  = sqrt_step(srem_s[j-1][c], qv[QuoW:QuoW-1], sroot_s[j-1][c]);
				sqv_d[j][c]   = {qv[QuoW-2:0], 2'b00};
				srem_d[j][c]  = r.rem;
				sroot_d[j][c] = r.root;
			end
		end
	end

	always_comb begin
		logic [RootW:0]   half;
		logic [UnitW-1:0] mag;
		for (int c = 0; c < 3; c++) begin
			half = ((RootW+1)'(sroot_s[SqrtSteps-1][c]) + 1'b1) >> 1;
			mag  = (half[UnitW-1:0] > UnitOne) ? UnitOne : half[UnitW-1:0];
			if (sdeg_s[SqrtSteps-1]) begin
				unit_d[c] = '0;
			end else if (sneg_s[SqrtSteps-1][c]) begin
				unit_d[c] = UnitW'(-mag);
			end else begin
				unit_d[c] = mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s    <= '0;
			sv_s    <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			dv_s    <= {dv_s[DivSteps-2:0], in_valid};
			sv_s    <= {sv_s[SqrtSteps-2:0], dv_s[DivSteps-1]};
			out_v_q <= sv_s[SqrtSteps-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s[0] <= in_item.neg;
			ddeg_s[0] <= in_item.degen;
			dsum_s[0] <= in_item.sum;
			for (int k = 1; k < DivSteps; k++) begin
				dneg_s[k] <= dneg_s[k-1];
				ddeg_s[k] <= ddeg_s[k-1];
				dsum_s[k] <= dsum_s[k-1];
			end
			drem_s    <= drem_d;
			dquo_s    <= dquo_d;
			sneg_s[0] <= dneg_s[DivSteps-1];
			sdeg_s[0] <= ddeg_s[DivSteps-1];
			for (int j = 1; j < SqrtSteps; j++) begin
				sneg_s[j] <= sneg_s[j-1];
				sdeg_s[j] <= sdeg_s[j-1];
			end
			sqv_s   <= sqv_d;
			srem_s  <= srem_d;
			sroot_s <= sroot_d;
			unit_q  <= unit_d;
			deg_q   <= sdeg_s[SqrtSteps-1];
		end
	end

	`NV3_IMPLY(a_degen_zero, out_v_q && deg_q, unit_q == '0, "degenerate result not zero")
	`NV3_IMPLY(a_unit_range, out_v_q && !deg_q, $signed(unit_q[0]) <= $signed(UnitOne) && $signed(unit_q[0]) >= -$signed(UnitOne), "x component beyond one")

endmodule

### sv/normalize_vector3.sv
// ----------------------------------------------------------------------------
// normalize_vector3
// Scales a signed Q7.8 vector to a signed Q1.14 unit vector.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  input    | in        | in_valid / in_ready   | vec_x, vec_y, vec_z
//  result   | out       | out_valid / out_ready | unit_x, unit_y, unit_z, degenerate
//  config   | in        | cfg_we                | cfg_data (min_length)
//
// One vector is taken and one result given per cycle when neither side stalls.
// The path runs through two front stages, the queue, a 31-step divider
// pipeline per component, a 16-step square root pipeline and the output register.
// The front stalls only when the queue is full; the back pipeline stalls as a
// whole while its output register holds a result that has not been transferred.
// Reset clears all valid flags, the queue and min_length; no clearing pass is run.
// ----------------------------------------------------------------------------
module normalize_vector3 import nv3_pkg::*; #(
	parameter int QueueDepth = nv3_pkg::QueueDepth
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [MinW-1:0]         cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VecW-1:0]  vec_x,
	input  logic signed [VecW-1:0]  vec_y,
	input  logic signed [VecW-1:0]  vec_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [UnitW-1:0] unit_x,
	output logic signed [UnitW-1:0] unit_y,
	output logic signed [UnitW-1:0] unit_z,
	output logic                    degenerate
);

	logic [MinW-1:0] min_length_q;
	logic            fq_valid;
	logic            fq_ready;
	nv3_item_t       fq_item;
	logic            qb_valid;
	logic            qb_ready;
	nv3_item_t       qb_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= '0;
		end else if (cfg_we) begin
			min_length_q <= cfg_data;
		end
	end

	nv3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.min_length (min_length_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.out_valid  (fq_valid),
		.out_ready  (fq_ready),
		.out_item   (fq_item)
	);

	nv3_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	nv3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (qb_valid),
		.in_ready   (qb_ready),
		.in_item    (qb_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.unit_x     (unit_x),
		.unit_y     (unit_y),
		.unit_z     (unit_z),
		.degenerate (degenerate)
	);

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for normalize_vector3. A short table of directed vectors
// is followed by random vectors under several min_length settings. Both sides
// idle at random, and the receiver holds off once for a long stretch so that
// the block fills up. Results are checked against table rows or an exact predictor.
// ----------------------------------------------------------------------------
module tb;
	import nv3_pkg::*;

	localparam int  NumRows   = 14;
	localparam int  RandItems = 1800;
	localparam int  Drain     = 80;
	localparam int  HoldLen   = 400;
	localparam longint CycleLimit = 1000000;

	typedef struct packed {
		logic signed [UnitW-1:0] ux;
		logic signed [UnitW-1:0] uy;
		logic signed [UnitW-1:0] uz;
		logic                    dg;
	} unit_res_t;

	typedef struct packed {
		logic [MinW-1:0]        min_len;
		logic signed [VecW-1:0] x;
		logic signed [VecW-1:0] y;
		logic signed [VecW-1:0] z;
		logic                   known;
		unit_res_t              res;
	} vec_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [MinW-1:0]         cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [VecW-1:0]  vec_x;
	logic signed [VecW-1:0]  vec_y;
	logic signed [VecW-1:0]  vec_z;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [UnitW-1:0] unit_x;
	logic signed [UnitW-1:0] unit_y;
	logic signed [UnitW-1:0] unit_z;
	logic                    degenerate;

	logic [MinW-1:0] min_len_now;
	unit_res_t       pending_units[$];
	int              errors;
	longint          cycles;
	bit              hold_req;

	vec_row_t rows[NumRows] = '{
		'{16'd0,     16'sd0,      16'sd0,      16'sd0,      1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
		'{16'd0,     16'sd256,    16'sd0,      16'sd0,      1'b1, '{16'sd16384, 16'sd0, 16'sd0, 1'b0}},
		'{16'd0,     -16'sd256,   16'sd0,      16'sd0,      1'b1, '{-16'sd16384, 16'sd0, 16'sd0, 1'b0}},
		'{16'd0,     16'sd0,      16'sd32767,  16'sd0,      1'b1, '{16'sd0, 16'sd16384, 16'sd0, 1'b0}},
		'{16'd0,     16'sd0,      16'sd0,      -16'sd32768, 1'b1, '{16'sd0, 16'sd0, -16'sd16384, 1'b0}},
		'{16'd0,     16'sd1,      16'sd0,      16'sd0,      1'b1, '{16'sd16384, 16'sd0, 16'sd0, 1'b0}},
		'{16'd0,     16'sd0,      -16'sd1,     16'sd0,      1'b1, '{16'sd0, -16'sd16384, 16'sd0, 1'b0}},
		'{16'd0,     16'sd768,    16'sd1024,   16'sd0,      1'b1, '{16'sd9830, 16'sd13107, 16'sd0, 1'b0}},
		'{16'd0,     16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '0},
		'{16'd0,     -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
		'{16'd0,     16'sd1,      -16'sd2,     16'sd3,      1'b0, '0},
		'{16'd256,   16'sd256,    16'sd0,      16'sd0,      1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
		'{16'd256,   16'sd0,      16'sd257,    16'sd0,      1'b1, '{16'sd0, 16'sd16384, 16'sd0, 1'b0}},
		'{16'd65535, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}}
	};

	normalize_vector3 u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.unit_x     (unit_x),
		.unit_y     (unit_y),
		.unit_z     (unit_z),
		.degenerate (degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Rounded |c| * 2^14 / sqrt(s), found as the largest n with (2n-1)^2 * s <= c^2 * 2^30.
	function automatic logic signed [UnitW-1:0] scale_component(logic signed [VecW-1:0] c,
			longint unsigned s);
		longint unsigned mag;
		longint unsigned bound;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned odd;
		mag   = (c < 0) ? longint'(-int'(c)) : longint'(c);
		bound = (mag * mag) << 30;
		lo    = 0;
		hi    = 16384;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 2 * mid - 1;
			if (odd * odd * s <= bound)
				lo = mid;
			else
				hi = mid - 1;
		end
		return (c < 0) ? -UnitW'(lo) : UnitW'(lo);
	endfunction

	function automatic unit_res_t normalize(logic signed [VecW-1:0] x,
			logic signed [VecW-1:0] y, logic signed [VecW-1:0] z, logic [MinW-1:0] min_len);
		longint unsigned s;
		longint unsigned floor_sq;
		unit_res_t       r;
		s        = longint'(int'(x) * int'(x)) + longint'(int'(y) * int'(y))
			+ longint'(int'(z) * int'(z));
		floor_sq = longint'(min_len) * longint'(min_len);
		if (s <= floor_sq)
			return '{16'sd0, 16'sd0, 16'sd0, 1'b1};
		r.ux = scale_component(x, s);
		r.uy = scale_component(y, s);
		r.uz = scale_component(z, s);
		r.dg = 1'b0;
		return r;
	endfunction

	task automatic send_vector(logic signed [VecW-1:0] x, logic signed [VecW-1:0] y,
			logic signed [VecW-1:0] z, bit known, unit_res_t res);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		gap  = (pick < 50) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		vec_x    <= x;
		vec_y    <= y;
		vec_z    <= z;
		do @(posedge clk); while (!in_ready);
		pending_units.push_back(known ? res : normalize(x, y, z, min_len_now));
	endtask

	task automatic set_min_length(logic [MinW-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_units.size() != 0) @(posedge clk);
		repeat (Drain) @(posedge clk);
		cfg_we      <= 1'b1;
		cfg_data    <= value;
		min_len_now  = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [VecW-1:0] random_component(int span);
		logic signed [VecW-1:0] v;
		unique case (span)
			0: v = $signed(VecW'($urandom));
			1: v = $signed(VecW'($urandom_range(0, 512))) - 16'sd256;
			default: v = $signed(VecW'($urandom_range(0, 8))) - 16'sd4;
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_units.size() == 0) begin
				$display("%0t: result with none expected: actual %0d %0d %0d %0b", $time,
					unit_x, unit_y, unit_z, degenerate);
				errors++;
			end else begin
				unit_res_t e;
				e = pending_units.pop_front();
				if (e.ux !== unit_x || e.uy !== unit_y || e.uz !== unit_z
						|| e.dg !== degenerate) begin
					$display("%0t: mismatch: expected %0d %0d %0d %0b, actual %0d %0d %0d %0b",
						$time, e.ux, e.uy, e.uz, e.dg, unit_x, unit_y, unit_z, degenerate);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		int pick;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HoldLen) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					out_ready <= 1'b1;
					n = $urandom_range(1, 40);
				end else begin
					out_ready <= 1'b0;
					n = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [MinW-1:0] settings[5];
		logic signed [VecW-1:0] x;
		logic signed [VecW-1:0] y;
		logic signed [VecW-1:0] z;
		int  span;
		int  pick;
		errors      = 0;
		hold_req    = 1'b0;
		min_len_now = '0;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		vec_x       <= '0;
		vec_y       <= '0;
		vec_z       <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NumRows; i++) begin
			if (rows[i].min_len != min_len_now)
				set_min_length(rows[i].min_len);
			send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);
		end

		settings = '{16'd0, 16'd65535, 16'd300, 16'(($urandom_range(0, 65535))), 16'd1};
		for (int p = 0; p < 5; p++) begin
			set_min_length(settings[p]);
			for (int i = 0; i < RandItems / 5; i++) begin
				if (p == 2 && i == 50)
					hold_req = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					// Vectors on and just beside the threshold length.
					if (min_len_now > 16'd32766)
						x = 16'sd32767;
					else
						x = $signed(min_len_now + ((pick < 5) ? 16'd0 : 16'd1));
					y = '0;
					z = '0;
				end else begin
					span = (pick < 60) ? 0 : (pick < 85) ? 1 : 2;
					x = random_component(span);
					y = random_component(span);
					z = random_component(span);
				end
				send_vector(x, y, z, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_units.size() != 0) @(posedge clk);
		repeat (Drain) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
